// File: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define VSAD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define VSAD_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define VSAD_ASSERT(lbl, clk, rstn, prop)
`define VSAD_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: rtl/vsad_pkg.sv
// Package with the types, constants and prefix table of the size/amplitude decoder.
package vsad_pkg;

    // Width of the running bit counter and of its output field.
    localparam int BIT_TOTAL_WIDTH = 20;
    localparam int TOTAL_FIELD_W   = 20;

    // Depth of the byte queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One input item as held in the queue.
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       final_byte;
    } item_t;

    // Queue head offered to the decode engine.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_item_t;

    // Prefix length and amplitude size of one code.
    typedef struct packed {
        logic [2:0] len;
        logic [3:0] size;
    } head_t;

    // Decode engine states.
    typedef enum logic {
        ST_IDLE,
        ST_DECODE
    } state_t;

    // Decodes the prefix from the six oldest buffered bits (oldest in bit 5).
    function automatic head_t prefix_decode(input logic [5:0] h);
        head_t r;
        priority if (!h[5])
        begin
            r.len  = 3'd2;
            r.size = h[4] ? 4'd2 : 4'd1;
        end
        else if (!h[4])
        begin
            r.len  = 3'd3;
            r.size = h[3] ? 4'd3 : 4'd0;
        end
        else if (!h[3])
        begin
            r.len  = 3'd3;
            r.size = 4'd4;
        end
        else if (!h[2])
        begin
            r.len  = 3'd4;
            r.size = 4'd5;
        end
        else if (!h[1])
        begin
            r.len  = 3'd5;
            r.size = 4'd6;
        end
        else
        begin
            r.len  = 3'd6;
            r.size = h[0] ? 4'd8 : 4'd7;
        end
        return r;
    endfunction

endpackage

// File: rtl/vsad_byte_if.sv
// Valid/ready channel that carries one stream byte per item.
interface vsad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       final_byte;

    modport source (output valid, output stream_byte, output final_byte, input ready);
    modport sink (input valid, input stream_byte, input final_byte, output ready);
endinterface

// File: rtl/vsad_coeff_if.sv
// Valid/ready channel that carries one decoded coefficient per item.
interface vsad_coeff_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] coeff_value;
    logic [3:0]        code_bits;
    logic [19:0]       bit_total;
    logic              run_last;

    modport source (output valid, output coeff_value, output code_bits,
                    output bit_total, output run_last, input ready);
    modport sink (input valid, input coeff_value, input code_bits,
                  input bit_total, input run_last, output ready);
endinterface

// File: rtl/vsad_front.sv
// Front end: accepts stream bytes and holds them in a short queue for the engine.
`include "assert_macros.svh"

module vsad_front (
    input  logic                clk,
    input  logic                rst_n,
    vsad_byte_if.sink           stream,
    output vsad_pkg::head_item_t head,
    input  logic                pop
);
    import vsad_pkg::*;

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic [QUEUE_CNT_W-1:0] cnt_next;
    logic                   push;
    logic                   do_pop;

    // Handshake and queue head.
    assign stream.ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push         = stream.valid && stream.ready;
    assign do_pop       = pop && (cnt_reg != '0);
    assign head.valid   = (cnt_reg != '0);
    assign head.item    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].stream_byte <= stream.stream_byte;
            slot_reg[wr_ptr_reg].final_byte  <= stream.final_byte;
        end
    end

    `VSAD_NEVER(a_fill_bound, clk, rst_n, cnt_reg > QUEUE_CNT_W'(QUEUE_DEPTH))
    `VSAD_ASSERT(a_pop_empties, clk, rst_n, (cnt_reg == QUEUE_CNT_W'(1) && do_pop && !push) |=> !head.valid)
    `VSAD_ASSERT(a_push_fills, clk, rst_n, (cnt_reg == '0 && push) |=> head.valid)

endmodule

// File: rtl/vsad_engine.sv
// Back end: bit buffer, prefix decoder; one code per cycle to a free output register.
`include "assert_macros.svh"

module vsad_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vsad_pkg::head_item_t head,
    output logic                 pop,
    vsad_coeff_if.source         coeff
);
    import vsad_pkg::*;

    // Buffer is left aligned: the oldest undecoded bit sits in bit 23.
    logic [23:0]                buf_reg;
    logic [23:0]                buf_next;
    logic [4:0]                 cnt_reg;
    logic [4:0]                 cnt_next;
    logic                       fin_reg;
    logic                       fin_next;
    logic [2:0]                 n_reg;
    logic [2:0]                 n_next;
    logic [BIT_TOTAL_WIDTH-1:0] total_reg;
    logic [BIT_TOTAL_WIDTH-1:0] total_next;
    state_t                     state_reg;
    state_t                     state_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [8:0]          value_reg;
    logic [3:0]                 bits_reg;
    logic [TOTAL_FIELD_W-1:0]   total_out_reg;
    logic                       last_reg;

    head_t                      hd;
    head_t                      nh;
    logic [3:0]                 code_len;
    logic [3:0]                 next_len;
    logic [23:0]                amp_win;
    logic [7:0]                 amp;
    logic [9:0]                 neg_val;
    logic signed [8:0]          value;
    logic [23:0]                rest;
    logic [4:0]                 remain;
    logic                       complete;
    logic                       partial;
    logic                       more;
    logic                       slot_free;
    logic                       emit;
    logic [3:0]                 emit_bits;
    logic [BIT_TOTAL_WIDTH-1:0] total_sum;

    // Head code: prefix, amplitude and sign extension.
    always_comb
    begin
        hd       = prefix_decode(buf_reg[23:18]);
        code_len = 4'(hd.len) + hd.size;
        amp_win  = buf_reg << hd.len;
        amp      = amp_win[23:16] >> (4'd8 - hd.size);
        neg_val  = {2'b00, amp} - (10'd1 << hd.size) + 10'd1;
        value    = amp_win[23] ? signed'({1'b0, amp}) : signed'(neg_val[8:0]);
    end

    // Look at the code after the head to tell whether this step goes on.
    always_comb
    begin
        rest     = buf_reg << code_len;
        remain   = cnt_reg - {1'b0, code_len};
        nh       = prefix_decode(rest[23:18]);
        next_len = 4'(nh.len) + nh.size;
        complete = (cnt_reg != '0) && ({1'b0, code_len} <= cnt_reg);
        partial  = !complete && fin_reg && (cnt_reg != '0);
        more     = complete && (n_reg != 3'd7) && (remain != '0) &&
                   (({1'b0, next_len} <= remain) || fin_reg);
    end

    assign slot_free = !out_valid_reg || coeff.ready;
    assign emit_bits = partial ? cnt_reg[3:0] : code_len;
    assign total_sum = total_reg + BIT_TOTAL_WIDTH'(emit_bits);

    // Sequencer: load a byte, then decode codes until the step is done.
    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        fin_next   = fin_reg;
        n_next     = n_reg;
        total_next = total_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    buf_next   = buf_reg | (24'(head.item.stream_byte) << (5'd16 - cnt_reg));
                    cnt_next   = cnt_reg + 5'd8;
                    fin_next   = head.item.final_byte;
                    n_next     = '0;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (complete || partial)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        buf_next   = rest;
                        cnt_next   = remain;
                        n_next     = n_reg + 1'b1;
                        total_next = total_sum;
                        if (!more)
                        begin
                            state_next = ST_IDLE;
                            if (fin_reg)
                            begin
                                buf_next = '0;
                                cnt_next = '0;
                            end
                        end
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                    if (fin_reg)
                    begin
                        buf_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (coeff.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            n_reg         <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            n_reg         <= n_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg     <= value;
            bits_reg      <= emit_bits;
            total_out_reg <= TOTAL_FIELD_W'(total_sum);
            last_reg      <= !more;
        end
    end

    assign coeff.valid       = out_valid_reg;
    assign coeff.coeff_value = value_reg;
    assign coeff.code_bits   = bits_reg;
    assign coeff.bit_total   = total_out_reg;
    assign coeff.run_last    = last_reg;

    `VSAD_ASSERT(a_idle_leftover, clk, rst_n, (state_reg == ST_IDLE) |-> (cnt_reg < 5'd14))
    `VSAD_ASSERT(a_clean_tail, clk, rst_n, (buf_reg << cnt_reg) == 24'd0)
    `VSAD_ASSERT(a_last_ends_step, clk, rst_n, (emit && !more) |=> (state_reg == ST_IDLE))
    `VSAD_ASSERT(a_final_clears, clk, rst_n, (emit && !more && fin_reg) |=> (cnt_reg == '0))

endmodule

// File: rtl/vlc_size_amplitude_decoder_top.sv
// Top level of the size/amplitude prefix-code decoder.
//
// The stream channel takes one byte of the coded bitstream per item, most
// significant bit first; final_byte marks the last byte of a stream. The
// coeff channel gives one item per decoded code: the signed value, the bits
// the code used, the running bit total and run_last on the last item that a
// byte causes. After a final byte, a code already started is finished with
// zero bits and the bit buffer is emptied; the bit total keeps running.
// A byte that completes no code gives no item.
// Bytes wait in a two-entry queue, so the stream side keeps accepting while
// the decoder works or the receiver stalls, until the queue fills. The
// decoder loads a byte from the queue into the bit buffer in its idle
// state, then decodes the codes that the buffer completes, one after
// another, in its decode state. The first item of a byte is offered
// from the output register once its first code is decoded. A stalled
// receiver holds the output register and the decoder waits; nothing is
// dropped.
// Reset clears the queue, the bit buffer and the bit total.

module vlc_size_amplitude_decoder_top (
    input  logic         clk,
    input  logic         rst_n,
    vsad_byte_if.sink    stream,
    vsad_coeff_if.source coeff
);
    import vsad_pkg::*;

    head_item_t head;
    logic       pop;

    vsad_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .head   (head),
        .pop    (pop)
    );

    vsad_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .coeff (coeff)
    );

endmodule

// File: sim/vlc_size_amplitude_decoder_top_tb.sv
// Self-checking testbench for the size/amplitude prefix-code decoder top level.
`timescale 1ns / 100ps

module vlc_size_amplitude_decoder_top_tb;

    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_ITEMS     = 250;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int TAIL_CYCLES      = 20;
    localparam int TOTAL_W          = vsad_pkg::TOTAL_FIELD_W;
    localparam int MAX_CODE_RESULTS = 8;
    localparam int DIRECTED_ROWS    = 18;

    // One decoded coefficient item as seen on the coeff channel.
    typedef struct packed {
        logic signed [8:0]  value;
        logic [3:0]         bits;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } coeff_t;

    // One row of the directed table; typed counts the items written out by hand.
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic [1:0] typed;
        coeff_t     lit_a;
        coeff_t     lit_b;
    } stim_row_t;

    localparam coeff_t NO_COEFF = '0;

    logic clk;
    logic rst_n;

    vsad_byte_if  stream_ch ();
    vsad_coeff_if coeff_ch ();

    vlc_size_amplitude_decoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .coeff  (coeff_ch)
    );

    // Decoder state kept by the testbench: undecoded bits, their count, bit total.
    logic [23:0]                          code_buf;
    logic [4:0]                           code_cnt;
    logic [vsad_pkg::BIT_TOTAL_WIDTH-1:0] bits_seen;

    coeff_t      byte_results [$];
    coeff_t      pending_coeffs [$];
    stim_row_t   rows [DIRECTED_ROWS];
    int          mismatches;
    int          idle_cycles;
    logic [15:0] stall_pattern;
    int          pattern_age;

    function automatic coeff_t coeff_item(input int value, input int bits, input int total,
                                          input bit last);
        coeff_t c;
        c.value = value[8:0];
        c.bits  = bits[3:0];
        c.total = total[TOTAL_W-1:0];
        c.last  = last;
        return c;
    endfunction

    // Bit i of the buffer counted from the oldest; bits past the end read as zero.
    function automatic logic buf_bit(input int i);
        int pos;
        pos = int'(code_cnt) - 1 - i;
        if (pos < 0)
            return 1'b0;
        return code_buf[pos];
    endfunction

    // Decodes the code at the head of the buffer into its full length and value.
    function automatic void parse_head(output int code_len, output int value);
        int size;
        int plen;
        int amp;
        if (!buf_bit(0))
        begin
            plen = 2;
            size = buf_bit(1) ? 2 : 1;
        end
        else if (!buf_bit(1))
        begin
            plen = 3;
            size = buf_bit(2) ? 3 : 0;
        end
        else if (!buf_bit(2))
        begin
            plen = 3;
            size = 4;
        end
        else if (!buf_bit(3))
        begin
            plen = 4;
            size = 5;
        end
        else if (!buf_bit(4))
        begin
            plen = 5;
            size = 6;
        end
        else
        begin
            plen = 6;
            size = buf_bit(5) ? 8 : 7;
        end
        amp = 0;
        for (int k = 0; k < size; k++)
            amp = amp * 2 + int'(buf_bit(plen + k));
        // Amplitudes in the lower half stand for negative values.
        if (size == 0)
            value = 0;
        else if (amp < (1 << (size - 1)))
            value = amp - (1 << size) + 1;
        else
            value = amp;
        code_len = plen + size;
    endfunction

    task automatic add_result(input int value, input int len);
        bits_seen = bits_seen + (vsad_pkg::BIT_TOTAL_WIDTH)'(len);
        byte_results.push_back(coeff_item(value, len, int'(bits_seen), 1'b0));
    endtask

    // Works out the items that one accepted stream byte causes.
    task automatic decode_stream_byte(input logic [7:0] data, input logic fin);
        int len;
        int value;
        bit stuck;
        byte_results.delete();
        code_buf = {code_buf[15:0], data};
        code_cnt = (code_cnt > 5'd16) ? 5'd24 : code_cnt + 5'd8;
        stuck = 1'b0;
        while (!stuck && code_cnt != 0 && byte_results.size() < MAX_CODE_RESULTS)
        begin
            parse_head(len, value);
            if (len > int'(code_cnt))
                stuck = 1'b1;
            else
            begin
                add_result(value, len);
                code_cnt = code_cnt - len[4:0];
                code_buf = code_buf & ((24'd1 << code_cnt) - 24'd1);
            end
        end
        // A final byte pads a started code with zeros; only real bits are counted.
        if (fin && code_cnt != 0 && byte_results.size() < MAX_CODE_RESULTS)
        begin
            parse_head(len, value);
            add_result(value, int'(code_cnt));
        end
        if (fin)
        begin
            code_buf = '0;
            code_cnt = '0;
        end
        if (byte_results.size() != 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
    endtask

    task automatic queue_prediction(input logic [7:0] data, input logic fin);
        decode_stream_byte(data, fin);
        foreach (byte_results[k])
            pending_coeffs.push_back(byte_results[k]);
    endtask

    // Offers one byte and returns at the edge where it is accepted.
    task automatic send_item(input logic [7:0] data, input logic fin);
        stream_ch.valid       <= 1'b1;
        stream_ch.stream_byte <= data;
        stream_ch.final_byte  <= fin;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_coeffs.size() != 0)
            @(posedge clk);
    endtask

    // Random bytes, leaning toward long prefixes and runs of equal bits.
    function automatic logic [7:0] random_stream_byte();
        logic [7:0] r;
        r = 8'($urandom);
        case ($urandom_range(0, 7))
            0: r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            1: r = r | 8'hF0;
            2: r = 8'h01 << $urandom_range(0, 7);
            3: r = ~(8'h01 << $urandom_range(0, 7));
            default: ;
        endcase
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic check_coeff();
        coeff_t want;
        if (pending_coeffs.size() == 0)
        begin
            mismatches++;
            $display("%0t: coeff item expected none actual value %0d bits %0d total %0d",
                     $time, coeff_ch.coeff_value, coeff_ch.code_bits, coeff_ch.bit_total);
        end
        else
        begin
            want = pending_coeffs.pop_front();
            compare_field("coeff_value", $signed(want.value), $signed(coeff_ch.coeff_value));
            compare_field("code_bits", int'(want.bits), int'(coeff_ch.code_bits));
            compare_field("bit_total", int'(want.total), int'(coeff_ch.bit_total));
            compare_field("run_last", int'(want.last), int'(coeff_ch.run_last));
        end
    endtask

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: checks accepted items and stalls on a pattern that changes now and then.
    initial
    begin
        coeff_ch.ready <= 1'b0;
        stall_pattern = '1;
        pattern_age = 0;
        forever
        begin
            @(posedge clk);
            if (coeff_ch.valid && coeff_ch.ready)
                check_coeff();
            if (rst_n)
            begin
                if (pattern_age == 0)
                begin
                    pattern_age = $urandom_range(20, 80);
                    case ($urandom_range(0, 3))
                        0: stall_pattern = '1;
                        1: stall_pattern = 16'($urandom);
                        2: stall_pattern = 16'($urandom | $urandom);
                        default: stall_pattern = 16'h0001;
                    endcase
                end
                pattern_age--;
                coeff_ch.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // Watchdog: ends the run when neither channel moves an item for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (stream_ch.valid && stream_ch.ready) ||
                (coeff_ch.valid && coeff_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus and final verdict.
    initial
    begin
        int items_left;
        int burst;
        logic [7:0] data;
        logic fin;

        rst_n                 <= 1'b0;
        stream_ch.valid       <= 1'b0;
        stream_ch.stream_byte <= '0;
        stream_ch.final_byte  <= 1'b0;
        code_buf   = '0;
        code_cnt   = '0;
        bits_seen  = '0;
        mismatches = 0;

        // Directed rows: all-zero and all-one bytes, both extremes of size 8, a final
        // byte that pads a started code, bytes that complete no code, every prefix.
        rows = '{
            '{8'h00, 1'b0, 2'd2, coeff_item(-1, 3, 3, 1'b0), coeff_item(-1, 3, 6, 1'b1)},
            '{8'hFF, 1'b1, 2'd2, coeff_item(1, 3, 9, 1'b0), coeff_item(128, 7, 16, 1'b1)},
            '{8'hFF, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'hFF, 1'b0, 2'd1, coeff_item(255, 14, 30, 1'b1), NO_COEFF},
            '{8'h00, 1'b1, 2'd2, coeff_item(-15, 7, 37, 1'b0), coeff_item(-1, 3, 40, 1'b1)},
            '{8'hFC, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h00, 1'b0, 2'd1, coeff_item(-255, 14, 54, 1'b1), NO_COEFF},
            '{8'h00, 1'b1, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h92, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'hB5, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'hE7, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'hF3, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h6A, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h49, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'hF8, 1'b0, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h80, 1'b1, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h7F, 1'b1, 2'd0, NO_COEFF, NO_COEFF},
            '{8'h01, 1'b1, 2'd0, NO_COEFF, NO_COEFF}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_item(rows[i].data, rows[i].fin);
            if (rows[i].typed == 2'd0)
                queue_prediction(rows[i].data, rows[i].fin);
            else
            begin
                // Keep the predictor in step, but expect the items written in the table.
                decode_stream_byte(rows[i].data, rows[i].fin);
                pending_coeffs.push_back(rows[i].lit_a);
                if (rows[i].typed == 2'd2)
                    pending_coeffs.push_back(rows[i].lit_b);
            end
            pause_sender($urandom_range(0, 2));
        end

        // Random part in bursts; halfway the sender holds off until all items are back.
        items_left = RANDOM_ITEMS;
        while (items_left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && items_left > 0)
            begin
                data = random_stream_byte();
                fin  = ($urandom_range(0, 6) == 0);
                send_item(data, fin);
                queue_prediction(data, fin);
                burst--;
                items_left--;
                if (items_left == RANDOM_ITEMS / 2)
                    wait_for_drain();
            end
            pause_sender($urandom_range(0, 10));
        end

        // Drain, then give stray items a chance to show up.
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vsad_pkg.sv
rtl/vsad_byte_if.sv
rtl/vsad_coeff_if.sv
rtl/vsad_front.sv
rtl/vsad_engine.sv
rtl/vlc_size_amplitude_decoder_top.sv
sim/vlc_size_amplitude_decoder_top_tb.sv
